[rtl/tun_pkg.sv]
// Shared constants and types for the triangle unit normal block.
// Used by every module under rtl; depends on nothing else.

package tun_pkg;

   // Fixed-point formats of the input coordinates and the output normal.
   localparam int COORD_WIDTH      = 16;
   localparam int COORD_FRAC_BITS  = 8;
   localparam int NORMAL_FRAC_BITS = 14;

   // Widths of the exact integer datapath.
   localparam int EDGE_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = PROD_W;
   localparam int HALF_W  = MAG_W / 2;
   localparam int HI_W    = MAG_W - HALF_W;
   localparam int PP_W    = 2 * HI_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int S_W     = SQ_W + 2;
   localparam int REM_W   = S_W + 1;

   // Quotient of c^2 * 2^(2F+2) / S, its square root and the output.
   localparam int Q_BITS = 2 * NORMAL_FRAC_BITS + 3;
   localparam int ROOT_W = NORMAL_FRAC_BITS + 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int SREM_W = ROOT_W + 3;
   localparam int OUT_W  = NORMAL_FRAC_BITS + 2;

   // Pipeline depths and queue geometry.
   localparam int FRONT_STAGES = 6;
   localparam int LANE_LAT     = Q_BITS + ROOT_W + 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // A length at or below 1e-6 means S * 10^12 <= 2^(4 * COORD_FRAC_BITS).
   localparam logic [S_W-1:0] DEGEN_S_MAX =
      S_W'((66'd1 << (4 * COORD_FRAC_BITS)) / 66'd1000000000000);

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [COORD_WIDTH-1:0] z;
   } vertex_type;

   typedef struct packed {
      vertex_type a;
      vertex_type b;
      vertex_type c;
   } tri_type;

   // One classified item waiting between the front and the back.
   typedef struct packed {
      logic [2:0][SQ_W-1:0] csq;
      logic [S_W-1:0]       sum_sq;
      logic [2:0]           neg;
      logic                 degen;
   } job_type;

endpackage

[rtl/triangle_unit_normal.sv]
// Triangle unit normal: Q8.8 vertices in, rounded Q2.14 unit normal out.
// From acceptance to rsp_valid an item passes 6 front stages, the queue,
// 49 lane stages and the output register.
// Throughput is one item per cycle while rsp_stall is low, set by the fully
// pipelined division (one quotient bit per stage) and square root (one root bit per stage).
// Synchronous active-high reset empties the pipelines and the queue.

module triangle_unit_normal (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_a_x,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_a_y,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_a_z,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_b_x,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_b_y,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_b_z,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_c_x,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_c_y,
   input  logic signed [tun_pkg::COORD_WIDTH-1:0]  req_c_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [tun_pkg::OUT_W-1:0]        rsp_norm_x,
   output logic signed [tun_pkg::OUT_W-1:0]        rsp_norm_y,
   output logic signed [tun_pkg::OUT_W-1:0]        rsp_norm_z,
   output logic                                    rsp_degenerate
);

   tun_pkg::tri_type   in_tri;
   tun_pkg::job_type   push_job;
   tun_pkg::job_type   pop_job;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_not_empty;

   // Gather the vertex ports into one item.
   always_comb begin
      in_tri.a.x = req_a_x;
      in_tri.a.y = req_a_y;
      in_tri.a.z = req_a_z;
      in_tri.b.x = req_b_x;
      in_tri.b.y = req_b_y;
      in_tri.b.z = req_b_z;
      in_tri.c.x = req_c_x;
      in_tri.c.y = req_c_y;
      in_tri.c.z = req_c_z;
   end

   tun_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_tri     (in_tri),
      .in_stall   (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   tun_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_job   (pop_job)
   );

   tun_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (queue_not_empty),
      .job            (pop_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_norm_x     (rsp_norm_x),
      .rsp_norm_y     (rsp_norm_y),
      .rsp_norm_z     (rsp_norm_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

[rtl/tun_front.sv]
// Front end: accepts triangles, forms the exact cross product, its squares
// and their sum, and flags degenerate triangles. Depends on tun_pkg.

module tun_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tun_pkg::tri_type  in_tri,
   output logic              in_stall,
   input  logic              queue_full,
   output logic              push,
   output tun_pkg::job_type  push_job
);

   logic [tun_pkg::FRONT_STAGES-1:0] fv_ff, fv_in;
   logic                             front_en;

   logic signed [tun_pkg::EDGE_W-1:0]  u_ff [3];
   logic signed [tun_pkg::EDGE_W-1:0]  v_ff [3];
   logic signed [tun_pkg::EDGE_W-1:0]  u_in [3];
   logic signed [tun_pkg::EDGE_W-1:0]  v_in [3];
   logic signed [tun_pkg::PROD_W-1:0]  p_ff [6];
   logic signed [tun_pkg::PROD_W-1:0]  p_in [6];
   logic [tun_pkg::MAG_W-1:0]          mag_ff [3];
   logic [tun_pkg::MAG_W-1:0]          mag_in [3];
   logic [2:0]                         neg3_ff, neg3_in;
   logic [tun_pkg::PP_W-1:0]           hh_ff [3];
   logic [tun_pkg::PP_W-1:0]           hl_ff [3];
   logic [tun_pkg::PP_W-1:0]           ll_ff [3];
   logic [tun_pkg::PP_W-1:0]           hh_in [3];
   logic [tun_pkg::PP_W-1:0]           hl_in [3];
   logic [tun_pkg::PP_W-1:0]           ll_in [3];
   logic [2:0]                         neg4_ff;
   logic [2:0][tun_pkg::SQ_W-1:0]      csq5_ff, csq5_in;
   logic [2:0]                         neg5_ff;
   tun_pkg::job_type                   job_ff, job_in;

   // The whole front advances unless its last item cannot enter the queue.
   assign front_en = !(fv_ff[tun_pkg::FRONT_STAGES-1] && queue_full);
   assign in_stall = !front_en;
   assign push     = fv_ff[tun_pkg::FRONT_STAGES-1] && !queue_full;
   assign push_job = job_ff;
   assign fv_in    = {fv_ff[tun_pkg::FRONT_STAGES-2:0], in_valid};

   // Edge vectors from the first vertex.
   always_comb begin
      u_in[0] = tun_pkg::EDGE_W'($signed(in_tri.b.x)) - tun_pkg::EDGE_W'($signed(in_tri.a.x));
      u_in[1] = tun_pkg::EDGE_W'($signed(in_tri.b.y)) - tun_pkg::EDGE_W'($signed(in_tri.a.y));
      u_in[2] = tun_pkg::EDGE_W'($signed(in_tri.b.z)) - tun_pkg::EDGE_W'($signed(in_tri.a.z));
      v_in[0] = tun_pkg::EDGE_W'($signed(in_tri.c.x)) - tun_pkg::EDGE_W'($signed(in_tri.a.x));
      v_in[1] = tun_pkg::EDGE_W'($signed(in_tri.c.y)) - tun_pkg::EDGE_W'($signed(in_tri.a.y));
      v_in[2] = tun_pkg::EDGE_W'($signed(in_tri.c.z)) - tun_pkg::EDGE_W'($signed(in_tri.a.z));
   end

   // The six products of the cross product.
   always_comb begin
      p_in[0] = u_ff[1] * v_ff[2];
      p_in[1] = u_ff[2] * v_ff[1];
      p_in[2] = u_ff[2] * v_ff[0];
      p_in[3] = u_ff[0] * v_ff[2];
      p_in[4] = u_ff[0] * v_ff[1];
      p_in[5] = u_ff[1] * v_ff[0];
   end

   // Cross product components as sign and magnitude.
   always_comb begin
      logic signed [tun_pkg::CROSS_W-1:0] n;
      for (int i = 0; i < 3; i++) begin
         n = tun_pkg::CROSS_W'(p_ff[2*i]) - tun_pkg::CROSS_W'(p_ff[2*i+1]);
         neg3_in[i] = n[tun_pkg::CROSS_W-1];
         mag_in[i]  = n[tun_pkg::CROSS_W-1] ? tun_pkg::MAG_W'(-n) : tun_pkg::MAG_W'(n);
      end
   end

   // Partial products of each square, split into high and low halves.
   always_comb begin
      logic [tun_pkg::HI_W-1:0] hi;
      logic [tun_pkg::HI_W-1:0] lo;
      for (int i = 0; i < 3; i++) begin
         hi = mag_ff[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W];
         lo = tun_pkg::HI_W'(mag_ff[i][tun_pkg::HALF_W-1:0]);
         hh_in[i] = hi * hi;
         hl_in[i] = hi * lo;
         ll_in[i] = lo * lo;
      end
   end

   // Recombine the partial products into full squares.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         csq5_in[i] = (tun_pkg::SQ_W'(hh_ff[i]) << (2 * tun_pkg::HALF_W))
                    + (tun_pkg::SQ_W'(hl_ff[i]) << (tun_pkg::HALF_W + 1))
                    + tun_pkg::SQ_W'(ll_ff[i]);
      end
   end

   // Sum of squares and the degenerate test.
   always_comb begin
      job_in.csq    = csq5_ff;
      job_in.neg    = neg5_ff;
      job_in.sum_sq = tun_pkg::S_W'(csq5_ff[0]) + tun_pkg::S_W'(csq5_ff[1])
                    + tun_pkg::S_W'(csq5_ff[2]);
      job_in.degen  = (job_in.sum_sq <= tun_pkg::DEGEN_S_MAX);
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (front_en) begin
         fv_ff <= fv_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (front_en) begin
         u_ff    <= u_in;
         v_ff    <= v_in;
         p_ff    <= p_in;
         mag_ff  <= mag_in;
         neg3_ff <= neg3_in;
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         neg4_ff <= neg3_ff;
         csq5_ff <= csq5_in;
         neg5_ff <= neg4_ff;
         job_ff  <= job_in;
      end
   end

endmodule

[rtl/tun_queue.sv]
// Short queue of classified items between the front and the back.
// Depends on tun_pkg for the item type and the depth.

module tun_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tun_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output tun_pkg::job_type  pop_job
);

   tun_pkg::job_type                mem_ff [tun_pkg::QUEUE_DEPTH];
   logic [tun_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tun_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tun_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == tun_pkg::QCNT_W'(tun_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/tun_lane.sv]
// One normal component: pipelined restoring division of c^2 * 2^(2F+2) by
// the sum of squares, a pipelined integer square root and rounding.
// Depends on tun_pkg.

module tun_lane (
   input  logic                       clock,
   input  logic                       en,
   input  logic [tun_pkg::SQ_W-1:0]   csq,
   input  logic [tun_pkg::S_W-1:0]    sum_sq,
   input  logic                       neg,
   output logic [tun_pkg::OUT_W-1:0]  norm
);

   logic [tun_pkg::REM_W-1:0]   drem_ff [tun_pkg::Q_BITS+1];
   logic [tun_pkg::REM_W-1:0]   drem_in [tun_pkg::Q_BITS+1];
   logic [tun_pkg::S_W-1:0]     dden_ff [tun_pkg::Q_BITS+1];
   logic [tun_pkg::S_W-1:0]     dden_in [tun_pkg::Q_BITS+1];
   logic [tun_pkg::Q_BITS-1:0]  dq_ff   [tun_pkg::Q_BITS+1];
   logic [tun_pkg::Q_BITS-1:0]  dq_in   [tun_pkg::Q_BITS+1];
   logic                        dneg_ff [tun_pkg::Q_BITS+1];
   logic                        dneg_in [tun_pkg::Q_BITS+1];
   logic [tun_pkg::RAD_W-1:0]   srad_ff [tun_pkg::ROOT_W+1];
   logic [tun_pkg::RAD_W-1:0]   srad_in [tun_pkg::ROOT_W+1];
   logic [tun_pkg::SREM_W-1:0]  srem_ff [tun_pkg::ROOT_W+1];
   logic [tun_pkg::SREM_W-1:0]  srem_in [tun_pkg::ROOT_W+1];
   logic [tun_pkg::ROOT_W-1:0]  root_ff [tun_pkg::ROOT_W+1];
   logic [tun_pkg::ROOT_W-1:0]  root_in [tun_pkg::ROOT_W+1];
   logic                        sneg_ff [tun_pkg::ROOT_W+1];
   logic                        sneg_in [tun_pkg::ROOT_W+1];

   // Division: one quotient bit per stage. The first step does not double,
   // because the squared component never exceeds the sum of squares.
   always_comb begin
      logic [tun_pkg::REM_W-1:0] trial;
      logic                      ge;
      drem_in[0] = tun_pkg::REM_W'(csq);
      dden_in[0] = sum_sq;
      dq_in[0]   = '0;
      dneg_in[0] = neg;
      for (int k = 0; k < tun_pkg::Q_BITS; k++) begin
         trial = (k == 0) ? drem_ff[k] : (drem_ff[k] << 1);
         ge    = (trial >= tun_pkg::REM_W'(dden_ff[k]));
         drem_in[k+1] = ge ? trial - tun_pkg::REM_W'(dden_ff[k]) : trial;
         dden_in[k+1] = dden_ff[k];
         dq_in[k+1]   = {dq_ff[k][tun_pkg::Q_BITS-2:0], ge};
         dneg_in[k+1] = dneg_ff[k];
      end
   end

   // Square root: one root bit per stage, two radicand bits consumed.
   always_comb begin
      logic [tun_pkg::SREM_W-1:0] rem2;
      logic [tun_pkg::SREM_W-1:0] strial;
      logic                       ge;
      srad_in[0] = tun_pkg::RAD_W'(dq_ff[tun_pkg::Q_BITS]);
      srem_in[0] = '0;
      root_in[0] = '0;
      sneg_in[0] = dneg_ff[tun_pkg::Q_BITS];
      for (int k = 0; k < tun_pkg::ROOT_W; k++) begin
         rem2   = {srem_ff[k][tun_pkg::SREM_W-3:0],
                   srad_ff[k][tun_pkg::RAD_W-1:tun_pkg::RAD_W-2]};
         strial = tun_pkg::SREM_W'({root_ff[k], 2'b01});
         ge     = (rem2 >= strial);
         srem_in[k+1] = ge ? rem2 - strial : rem2;
         root_in[k+1] = {root_ff[k][tun_pkg::ROOT_W-2:0], ge};
         srad_in[k+1] = srad_ff[k] << 2;
         sneg_in[k+1] = sneg_ff[k];
      end
   end

   // Halving the doubled root with a carry in gives round to nearest,
   // ties away from zero; the sign is applied last.
   always_comb begin
      logic [tun_pkg::ROOT_W:0]   rsum;
      logic [tun_pkg::OUT_W-1:0]  mag;
      rsum = {1'b0, root_ff[tun_pkg::ROOT_W]} + (tun_pkg::ROOT_W+1)'(1);
      mag  = tun_pkg::OUT_W'(rsum[tun_pkg::ROOT_W:1]);
      norm = sneg_ff[tun_pkg::ROOT_W] ? ('0 - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff <= drem_in;
         dden_ff <= dden_in;
         dq_ff   <= dq_in;
         dneg_ff <= dneg_in;
         srad_ff <= srad_in;
         srem_ff <= srem_in;
         root_ff <= root_in;
         sneg_ff <= sneg_in;
      end
   end

endmodule

[rtl/tun_back.sv]
// Back end: takes items from the queue, runs three normal lanes in step
// and holds the result item in an output register. Depends on tun_pkg
// and tun_lane.

module tun_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  tun_pkg::job_type           job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [tun_pkg::OUT_W-1:0]  rsp_norm_x,
   output logic [tun_pkg::OUT_W-1:0]  rsp_norm_y,
   output logic [tun_pkg::OUT_W-1:0]  rsp_norm_z,
   output logic                       rsp_degenerate
);

   logic                              back_en;
   logic [tun_pkg::LANE_LAT-1:0]      bv_ff, bv_in;
   logic [tun_pkg::LANE_LAT-1:0]      bd_ff, bd_in;
   logic [2:0][tun_pkg::OUT_W-1:0]    lane_norm;
   logic                              rsp_valid_ff;
   logic [2:0][tun_pkg::OUT_W-1:0]    rsp_norm_ff, rsp_norm_in;
   logic                              rsp_degen_ff;

   // The back advances unless a finished item is held by the consumer.
   assign back_en = !(rsp_valid_ff && rsp_stall);
   assign pop     = back_en && job_valid;
   assign bv_in   = {bv_ff[tun_pkg::LANE_LAT-2:0], pop};
   assign bd_in   = {bd_ff[tun_pkg::LANE_LAT-2:0], job.degen};

   for (genvar i = 0; i < 3; i++) begin : g_lane
      tun_lane u_lane (
         .clock  (clock),
         .en     (back_en),
         .csq    (job.csq[i]),
         .sum_sq (job.sum_sq),
         .neg    (job.neg[i]),
         .norm   (lane_norm[i])
      );
   end

   // A degenerate item yields a zero normal.
   assign rsp_norm_in = bd_ff[tun_pkg::LANE_LAT-1] ? '0 : lane_norm;

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         bv_ff        <= bv_in;
         rsp_valid_ff <= bv_ff[tun_pkg::LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         bd_ff        <= bd_in;
         rsp_norm_ff  <= rsp_norm_in;
         rsp_degen_ff <= bd_ff[tun_pkg::LANE_LAT-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_norm_x     = rsp_norm_ff[0];
   assign rsp_norm_y     = rsp_norm_ff[1];
   assign rsp_norm_z     = rsp_norm_ff[2];
   assign rsp_degenerate = rsp_degen_ff;

endmodule
